### rtl/core/pba_pkg.sv
// Shared types, operation codes and map helpers for the page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

	// Default geometry: 160 pages of 4 KiB (0 to 640 KiB)
	localparam int DEF_TRACKED_PAGES = 160;
	localparam int DEF_PAGE_BYTES    = 4096;

	// Field widths
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 32;
	localparam int BLOCK_W  = 20;
	localparam int WORD_W   = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INIT = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND = 2'd2;

	// Request transaction
	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] start_address;
		logic [LEN_W-1:0]  byte_count;
	} in_t;

	// Response transaction
	typedef struct packed {
		logic [LEN_W-1:0]   echoed_length;
		logic               found;
		logic [BLOCK_W-1:0] block_address;
	} out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // capture request fields, set up counters
		logic init_map;   // rewrite map to its initial contents
		logic step_mark;  // set one page bit and advance
		logic step_find;  // test one page bit and advance
		logic publish;    // load the response register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mark_done;
		logic find_done;
	} sts_t;

	// Initial contents of map word w: first and last tracked page set
	function automatic logic [WORD_W-1:0] init_word(input int w, input int tracked);
		logic [WORD_W-1:0] word;
		int                last;
		word = '0;
		last = tracked - 1;
		if (w == 0) begin
			word[0] = 1'b1;
		end
		if (w == (last >> 5)) begin
			word[last[4:0]] = 1'b1;
		end
		return word;
	endfunction

endpackage
`default_nettype wire

### rtl/core/pba_ctrl.sv
// Sequencing state machine for the page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
module pba_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [pba_pkg::OP_W-1:0] operation,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output pba_pkg::cmd_t                 cmd,
	input  wire pba_pkg::sts_t            sts
);
	import pba_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_MARK = 3'd2;
	localparam logic [2:0] ST_FIND = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// Response register can take a new result when empty or draining now
	assign slot_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (operation)
						OP_INIT: state_nxt = ST_INIT;
						OP_MARK: state_nxt = ST_MARK;
						OP_FIND: state_nxt = ST_FIND;
						default: state_nxt = ST_DONE;
					endcase
				end
			end
			ST_INIT: begin
				cmd.init_map = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_MARK: begin
				if (sts.mark_done) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.step_mark = 1'b1;
				end
			end
			ST_FIND: begin
				if (sts.find_done) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.step_find = 1'b1;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/pba_datapath.sv
// Bitmap storage, page walker and response register for the page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
module pba_datapath #(
	parameter int TrackedPages = pba_pkg::DEF_TRACKED_PAGES,
	parameter int PageBytes    = pba_pkg::DEF_PAGE_BYTES
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pba_pkg::in_t  in_data,
	input  wire pba_pkg::cmd_t cmd,
	output pba_pkg::sts_t      sts,
	output pba_pkg::out_t      out_data
);
	import pba_pkg::*;

	// PageBytes is a power of two; page number is a plain shift
	localparam int SHIFT     = $clog2(PageBytes);
	localparam int PAGE_W    = $clog2(TrackedPages + 1);
	localparam int CNT_W     = LEN_W + 1 - SHIFT;
	localparam int MAP_WORDS = (TrackedPages + WORD_W - 1) / WORD_W;
	localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam logic [PAGE_W-1:0] PAGE_END = PAGE_W'(TrackedPages);

	logic [OP_W-1:0]   op_q;
	logic [LEN_W-1:0]  len_q;
	logic [PAGE_W-1:0] ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PAGE_W-1:0] run_q;
	logic [PAGE_W-1:0] start_q;
	logic              hit_q;
	logic [WORD_W-1:0] map_q [MAP_WORDS];
	out_t              out_q;

	logic [ADDR_W-1:0] addr_page;
	logic              addr_beyond;
	logic [LEN_W:0]    len_round;
	logic [CNT_W-1:0]  mark_pages;
	logic [CNT_W-1:0]  want_pages;
	logic [WIDX_W-1:0] word_idx;
	logic [4:0]        bit_idx;
	logic              page_used;
	logic [PAGE_W-1:0] run_inc;
	logic              run_hit;
	logic              res_found;
	logic [ADDR_W-1:0] run_bytes;
	out_t              res;

	// Request decode: first page, rounded-up and truncated page counts
	assign addr_page   = in_data.start_address >> SHIFT;
	assign addr_beyond = (addr_page >= ADDR_W'(TrackedPages));
	assign len_round   = {1'b0, in_data.byte_count} + (LEN_W + 1)'(PageBytes - 1);
	assign mark_pages  = CNT_W'(len_round >> SHIFT);
	assign want_pages  = CNT_W'(in_data.byte_count >> SHIFT);

	// Current page bit
	assign word_idx  = WIDX_W'(ptr_q >> 5);
	assign bit_idx   = ptr_q[4:0];
	assign page_used = map_q[word_idx][bit_idx];
	assign run_inc   = run_q + PAGE_W'(1);
	assign run_hit   = (CNT_W'(run_inc) == cnt_q);

	// Walk termination
	assign sts.mark_done = (cnt_q == '0) || (ptr_q == PAGE_END);
	assign sts.find_done = hit_q || (cnt_q == '0) || (ptr_q == PAGE_END);

	// Walker registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_data.operation;
			len_q <= in_data.byte_count;
			run_q <= '0;
			start_q <= '0;
			if (in_data.operation == OP_MARK) begin
				ptr_q <= addr_beyond ? PAGE_END : PAGE_W'(addr_page);
				cnt_q <= mark_pages;
			end else begin
				ptr_q <= '0;
				cnt_q <= want_pages;
			end
		end else if (cmd.step_mark) begin
			ptr_q <= ptr_q + PAGE_W'(1);
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (cmd.step_find) begin
			ptr_q <= ptr_q + PAGE_W'(1);
			if (page_used) begin
				run_q <= '0;
			end else begin
				run_q <= run_inc;
				if (run_q == '0) begin
					start_q <= ptr_q;
				end
			end
		end
	end

	// Hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q <= 1'b0;
		end else if (cmd.step_find && !page_used && run_hit) begin
			hit_q <= 1'b1;
		end
	end

	// Page bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < MAP_WORDS; w++) begin
				map_q[w] <= init_word(w, TrackedPages);
			end
		end else if (cmd.init_map) begin
			for (int w = 0; w < MAP_WORDS; w++) begin
				map_q[w] <= init_word(w, TrackedPages);
			end
		end else if (cmd.step_mark) begin
			map_q[word_idx][bit_idx] <= 1'b1;
		end
	end

	// Response formatting
	assign res_found = (op_q == OP_FIND) && hit_q;
	assign run_bytes = ADDR_W'(start_q) << SHIFT;
	always_comb begin
		res               = '0;
		res.found         = res_found;
		res.echoed_length = (op_q == OP_MARK) ? len_q : '0;
		res.block_address = res_found ? run_bytes[BLOCK_W-1:0] : '0;
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_q <= res;
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

### rtl/core/page_bitmap_allocator_top.sv
// Top level of the page bitmap allocator: controller plus bitmap datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  request | in        | in_valid / in_ready   | in_data  (pba_pkg::in_t)
//  result  | out       | out_valid / out_ready | out_data (pba_pkg::out_t)
//
// One request is worked at a time; each yields exactly one result.
// On acceptance the controller enters ST_INIT, ST_MARK or ST_FIND (ST_DONE
// for an unused operation). Mark sets N pages (N at most TrackedPages), find
// scans pages up to a hit or the map end. in_ready returns on the edge that
// raises out_valid.
// The page walker reads and writes one bitmap bit per cycle.
// A result waiting in the output register blocks only the next completion.
// After reset the map holds the first and last pages marked used.
`timescale 1ns / 1ps
`default_nettype none
module page_bitmap_allocator_top #(
	parameter int TrackedPages = pba_pkg::DEF_TRACKED_PAGES,
	parameter int PageBytes    = pba_pkg::DEF_PAGE_BYTES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire pba_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output pba_pkg::out_t     out_data
);
	import pba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (in_data.operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pba_datapath #(
		.TrackedPages (TrackedPages),
		.PageBytes    (PageBytes)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
`default_nettype wire
